// File: hdl/ncs_pkg.sv
package ncs_pkg;

  localparam int MaxKnots = 64;
  localparam int FracBits = 16;
  localparam int IdxW = $clog2(MaxKnots);
  localparam int CntW = $clog2(MaxKnots + 1);
  localparam int VW = 48;
  localparam int DivSteps = 48 + FracBits;

  localparam logic signed [VW-1:0] Lim48 = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] Min48 = {1'b1, {(VW-1){1'b0}}};

  localparam logic [2:0] StValue   = 3'd0;
  localparam logic [2:0] StBuilt   = 3'd1;
  localparam logic [2:0] StFew     = 3'd2;
  localparam logic [2:0] StNotInc  = 3'd3;
  localparam logic [2:0] StTooMany = 3'd4;

  typedef enum logic [1:0] {
    AluMul,
    AluDiv
  } alu_op_t;

  typedef struct packed {
    logic    go;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,
    S_CHK_RD,
    S_F_RD,
    S_F_RD2,
    S_F_Q1,
    S_F_Q2,
    S_F_L,
    S_F_MU,
    S_F_ZM,
    S_F_Z,
    S_B_RD,
    S_B_C,
    S_B_Q1,
    S_B_M,
    S_B_Q2,
    S_B_D,
    S_E_SCAN,
    S_E_RD,
    S_E_M1,
    S_E_M2,
    S_E_M3,
    S_DONE,
    S_WAIT
  } state_t;

  function automatic logic signed [VW-1:0] sat48(input logic signed [VW+1:0] v);
    if (v > $signed({2'b00, Lim48})) return Lim48;
    if (v < $signed({2'b11, Min48})) return Min48;
    return v[VW-1:0];
  endfunction

endpackage

// File: hdl/ncs_alu.sv
module ncs_alu (
  input  logic                               clk,
  input  logic                               rst,
  input  ncs_pkg::alu_req_t                  req,
  input  logic signed [ncs_pkg::VW-1:0]      a,
  input  logic signed [ncs_pkg::VW-1:0]      b,
  output logic                               done,
  output logic signed [ncs_pkg::VW-1:0]      res
);
  import ncs_pkg::*;

  // Shared unit: multiply by 16-bit digits of b, or restoring division
  // one quotient bit a cycle.
  localparam int DigW = 16;
  localparam int NDig = VW / DigW;
  localparam int PW = 2 * VW;
  localparam int CW = $clog2(DivSteps + 1);
  localparam int UaIdxW = $clog2(VW);

  logic              busy;
  alu_op_t           op;
  logic              neg;
  logic [VW-1:0]     ua, ub;
  logic [PW-1:0]     prod;
  logic [VW:0]       rem;
  logic [VW:0]       q;
  logic              qsat;
  logic [CW-1:0]     cnt;

  logic [VW-1:0]     mag_a, mag_b;
  logic [DigW-1:0]   dig;
  logic [PW-1:0]     pp;
  logic [VW:0]       rem_sh;
  logic              nbit;
  logic [PW-1:0]     rnd;
  logic [VW-1:0]     m;
  logic [VW:0]       q_next;
  logic [VW:0]       rem_next;
  logic              fin;

  assign mag_a = a[VW-1] ? VW'(-a) : a;
  assign mag_b = b[VW-1] ? VW'(-b) : b;

  always_comb begin
    dig = ub[cnt[1:0]*DigW +: DigW];
    pp = PW'(ua) * PW'(dig);
    nbit = (cnt >= CW'(FracBits + 1)) ? ua[UaIdxW'(cnt - CW'(FracBits + 1))] : 1'b0;
    rem_sh = {rem[VW-1:0], nbit};
    if (rem_sh >= {1'b0, ub}) begin
      rem_next = rem_sh - {1'b0, ub};
      q_next = {q[VW-1:0], 1'b1};
    end else begin
      rem_next = rem_sh;
      q_next = {q[VW-1:0], 1'b0};
    end
    rnd = prod + (PW'(1) << (FracBits - 1));
    if (op == AluMul) begin
      if (rnd[PW-1 -: (PW-VW-FracBits+1)] != '0) m = Lim48;
      else m = rnd[FracBits +: VW];
    end else if (ub == '0) begin
      m = (ua == '0) ? '0 : Lim48;
    end else if (qsat) begin
      m = Lim48;
    end else if (rem >= {1'b0, ub} - rem) begin
      m = (q[VW-1:0] == Lim48) ? Lim48 : VW'(q + 1'b1);
    end else begin
      m = q[VW-1:0];
    end
    if (op == AluMul) fin = busy && (cnt == CW'(NDig));
    else fin = busy && (cnt == '0 || qsat || ub == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      if (req.go && !busy) begin
        busy <= 1'b1;
        op <= req.op;
        neg <= a[VW-1] ^ b[VW-1];
        ua <= mag_a;
        ub <= mag_b;
        prod <= '0;
        rem <= '0;
        q <= '0;
        qsat <= 1'b0;
        cnt <= (req.op == AluMul) ? CW'(0) : CW'(DivSteps);
      end else if (busy) begin
        if (fin) begin
          busy <= 1'b0;
          res <= neg ? VW'(-m) : m;
        end else if (op == AluMul) begin
          prod <= prod + (pp << (cnt[1:0] * DigW));
          cnt <= cnt + 1'b1;
        end else begin
          rem <= rem_next;
          q <= q_next;
          if (q_next > {1'b0, Lim48}) qsat <= 1'b1;
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // The multiplier leaves prod alone on the last digit index overflow step.
  always_ff @(posedge clk) begin
    if (!rst && busy && op == AluMul && cnt == CW'(NDig)) begin
      assert (!done) else $error("mul finished twice");
    end
  end
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_go_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    (busy && op == AluDiv && ub == '0) |=> done) else $error("zero divisor stalls");

endmodule

// File: hdl/natural_cubic_spline_unit.sv
// Natural cubic spline unit. Set start for one cycle while busy is low.
// A load that is not the last knot leaves busy low; a last-knot load
// runs a build through one shared multiply/divide unit. An evaluation
// scans the knot memory segment by segment and then does three
// multiplies. Each result appears for one cycle with valid high; it
// cannot be held off, so the receiver must take it then.
module natural_cubic_spline_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic signed [31:0] position,
  input  logic signed [31:0] knot_level,
  input  logic               last_knot,
  output logic               valid,
  output logic signed [31:0] result_level,
  output logic [5:0]         segment,
  output logic [2:0]         status
);
  import ncs_pkg::*;

  logic signed [VW-1:0] m_pos [MaxKnots];
  logic signed [VW-1:0] m_a   [MaxKnots];
  logic signed [VW-1:0] m_b   [MaxKnots];
  logic signed [VW-1:0] m_c   [MaxKnots];
  logic signed [VW-1:0] m_d   [MaxKnots];
  logic signed [VW-1:0] m_mu  [MaxKnots];
  logic signed [VW-1:0] m_z   [MaxKnots];

  state_t state, state_next;
  logic [CntW-1:0] knot_count;
  logic spline_ready, set_ovf;
  logic [IdxW-1:0] i;
  logic signed [VW-1:0] xq;
  logic signed [VW-1:0] p0, p1, p2, a0, a1, a2, c1, mu0, z0;
  logic signed [VW-1:0] t1, t2, lreg, acc;

  alu_req_t aq;
  logic signed [VW-1:0] aa, ab, ar;
  logic ad;
  logic issued;

  logic [CntW-1:0] ld_base, ld_cnt;
  logic ld_ovf;

  ncs_alu u_alu (.clk, .rst, .req(aq), .a(aa), .b(ab), .done(ad), .res(ar));

  logic [IdxW-1:0] kidx;
  assign kidx = IdxW'(knot_count - 1'b1);

  logic signed [VW-1:0] hp, hn, h;
  assign hp = p1 - p0;
  assign hn = p2 - p1;
  assign h  = p1 - p0;

  always_comb begin
    ld_base = spline_ready ? '0 : knot_count;
    ld_ovf = (!spline_ready && set_ovf) || (ld_base >= CntW'(MaxKnots));
    ld_cnt = (ld_base < CntW'(MaxKnots)) ? ld_base + 1'b1 : ld_base;
  end

  always_comb begin
    state_next = state;
    aq = '{go: 1'b0, op: AluMul};
    aa = '0;
    ab = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (operation) begin
            state_next = (!spline_ready || knot_count < CntW'(2)) ? S_DONE : S_E_SCAN;
          end else if (last_knot) begin
            state_next = (ld_ovf || ld_cnt < CntW'(2)) ? S_DONE : S_CHK;
          end
        end
      end
      S_CHK: state_next = S_CHK_RD;
      S_CHK_RD: begin
        if (p1 <= p0) state_next = S_DONE;
        else if (i + 1'b1 == kidx) state_next = (kidx == IdxW'(1)) ? S_B_RD : S_F_RD;
        else state_next = S_CHK;
      end
      S_F_RD: state_next = S_F_RD2;
      S_F_RD2: state_next = S_F_Q1;
      S_F_Q1: begin
        aq = '{go: !issued, op: AluDiv};
        aa = sat48(3 * ($signed({{2{a2[VW-1]}}, a2}) - a1));
        ab = hn;
        if (ad) state_next = S_F_Q2;
      end
      S_F_Q2: begin
        aq = '{go: !issued, op: AluDiv};
        aa = sat48(3 * ($signed({{2{a1[VW-1]}}, a1}) - a0));
        ab = hp;
        if (ad) state_next = S_F_L;
      end
      S_F_L: begin
        aq = '{go: !issued, op: AluMul};
        aa = hp; ab = mu0;
        if (ad) state_next = S_F_MU;
      end
      S_F_MU: begin
        aq = '{go: !issued, op: AluDiv};
        aa = hn; ab = lreg;
        if (ad) state_next = S_F_ZM;
      end
      S_F_ZM: begin
        aq = '{go: !issued, op: AluMul};
        aa = hp; ab = z0;
        if (ad) state_next = S_F_Z;
      end
      S_F_Z: begin
        aq = '{go: !issued, op: AluDiv};
        aa = sat48($signed({{2{t1[VW-1]}}, t1}) - ar); ab = lreg;
        if (ad) state_next = (i + 1'b1 == kidx) ? S_B_RD : S_F_RD;
      end
      S_B_RD: state_next = S_B_C;
      S_B_C: begin
        aq = '{go: !issued, op: AluMul};
        aa = mu0; ab = c1;
        if (ad) state_next = S_B_Q1;
      end
      S_B_Q1: begin
        aq = '{go: !issued, op: AluDiv};
        aa = a1 - a0; ab = h;
        if (ad) state_next = S_B_M;
      end
      S_B_M: begin
        aq = '{go: !issued, op: AluMul};
        aa = h; ab = sat48($signed({{2{c1[VW-1]}}, c1}) + 2 * t2);
        if (ad) state_next = S_B_Q2;
      end
      S_B_Q2: begin
        aq = '{go: !issued, op: AluDiv};
        aa = lreg; ab = VW'(3) << FracBits;
        if (ad) state_next = S_B_D;
      end
      S_B_D: begin
        aq = '{go: !issued, op: AluDiv};
        aa = sat48($signed({{2{c1[VW-1]}}, c1}) - t2); ab = sat48(3 * h);
        if (ad) state_next = (i == '0) ? S_DONE : S_B_RD;
      end
      S_E_SCAN: state_next = S_E_RD;
      S_E_RD: begin
        if (IdxW'(i + 1'b1) < kidx && xq > p1) state_next = S_E_SCAN;
        else state_next = S_E_M1;
      end
      S_E_M1: begin
        aq = '{go: !issued, op: AluMul}; aa = acc; ab = t1;
        if (ad) state_next = S_E_M2;
      end
      S_E_M2: begin
        aq = '{go: !issued, op: AluMul}; aa = acc; ab = t1;
        if (ad) state_next = S_E_M3;
      end
      S_E_M3: begin
        aq = '{go: !issued, op: AluMul}; aa = acc; ab = t1;
        if (ad) state_next = S_DONE;
      end
      S_DONE: state_next = S_WAIT;
      S_WAIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count <= '0;
      spline_ready <= 1'b0;
      set_ovf <= 1'b0;
      valid <= 1'b0;
      issued <= 1'b0;
    end else begin
      valid <= (state == S_DONE);
      issued <= ad ? 1'b0 : (aq.go ? 1'b1 : issued);
      unique case (state)
        S_IDLE: if (start) begin
          xq <= VW'(position);
          i <= '0;
          if (operation) begin
            if (!spline_ready || knot_count < CntW'(2)) begin
              result_level <= '0; segment <= '0; status <= StValue;
            end
          end else begin
            spline_ready <= 1'b0;
            if (ld_base < CntW'(MaxKnots)) begin
              m_pos[IdxW'(ld_base)] <= VW'(position);
              m_a[IdxW'(ld_base)] <= VW'(knot_level);
            end
            result_level <= '0; segment <= '0;
            if (last_knot && (ld_ovf || ld_cnt < CntW'(2))) begin
              status <= ld_ovf ? StTooMany : StFew;
              knot_count <= '0; set_ovf <= 1'b0;
            end else begin
              knot_count <= ld_cnt;
              set_ovf <= ld_ovf;
            end
          end
        end
        S_CHK: begin
          p0 <= m_pos[i]; p1 <= m_pos[IdxW'(i + 1'b1)];
        end
        S_CHK_RD: begin
          if (p1 <= p0) begin
            status <= StNotInc; knot_count <= '0;
          end else if (i + 1'b1 == kidx) begin
            m_mu[0] <= '0; m_z[0] <= '0;
            mu0 <= '0; z0 <= '0;
            c1 <= '0;
            i <= (kidx == IdxW'(1)) ? '0 : IdxW'(1);
            m_mu[kidx] <= '0; m_z[kidx] <= '0;
            m_c[kidx] <= '0; m_b[kidx] <= '0; m_d[kidx] <= '0;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_F_RD: begin
          p0 <= m_pos[i - 1'b1]; p1 <= m_pos[i];
          a0 <= m_a[i - 1'b1]; a1 <= m_a[i];
        end
        S_F_RD2: begin
          p2 <= m_pos[IdxW'(i + 1'b1)]; a2 <= m_a[IdxW'(i + 1'b1)];
        end
        S_F_Q1: if (ad) t1 <= ar;
        S_F_Q2: if (ad) t1 <= sat48($signed({{2{t1[VW-1]}}, t1}) - ar);
        S_F_L: if (ad) lreg <= sat48(2 * ($signed({{2{p2[VW-1]}}, p2}) - p0) - ar);
        S_F_MU: if (ad) begin
          m_mu[i] <= ar; mu0 <= ar;
        end
        S_F_ZM: ;
        S_F_Z: if (ad) begin
          m_z[i] <= ar; z0 <= ar;
          if (i + 1'b1 == kidx) begin
            c1 <= '0; i <= kidx - 1'b1;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_B_RD: begin
          p0 <= m_pos[i]; p1 <= m_pos[IdxW'(i + 1'b1)];
          a0 <= m_a[i]; a1 <= m_a[IdxW'(i + 1'b1)];
          mu0 <= m_mu[i]; z0 <= m_z[i];
        end
        S_B_C: if (ad) begin
          t2 <= sat48($signed({{2{z0[VW-1]}}, z0}) - ar);
          m_c[i] <= sat48($signed({{2{z0[VW-1]}}, z0}) - ar);
        end
        S_B_Q1: if (ad) t1 <= ar;
        S_B_M: if (ad) lreg <= ar;
        S_B_Q2: if (ad) m_b[i] <= sat48($signed({{2{t1[VW-1]}}, t1}) - ar);
        S_B_D: if (ad) begin
          m_d[i] <= ar;
          c1 <= t2;
          if (i == '0) begin
            spline_ready <= 1'b1; status <= StBuilt;
          end else begin
            i <= i - 1'b1;
          end
        end
        S_E_SCAN: begin
          p0 <= m_pos[i]; p1 <= m_pos[IdxW'(i + 1'b1)];
        end
        S_E_RD: begin
          if (IdxW'(i + 1'b1) < kidx && xq > p1) begin
            i <= i + 1'b1;
          end else begin
            t1 <= xq - p0;
            acc <= m_d[i];
            c1 <= m_c[i];
            t2 <= m_b[i];
            a0 <= m_a[i];
          end
        end
        S_E_M1: if (ad) acc <= sat48($signed({{2{ar[VW-1]}}, ar}) + c1);
        S_E_M2: if (ad) acc <= sat48($signed({{2{ar[VW-1]}}, ar}) + t2);
        S_E_M3: if (ad) begin
          logic signed [VW-1:0] s;
          s = sat48($signed({{2{ar[VW-1]}}, ar}) + a0);
          if (s > 48'sh7FFFFFFF) result_level <= 32'sh7FFFFFFF;
          else if (s < -48'sh80000000) result_level <= 32'sh80000000;
          else result_level <= s[31:0];
          segment <= 6'(i);
          status <= StValue;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    busy = (state != S_IDLE);
  end

  a_valid_pulse: assert property (@(posedge clk) disable iff (rst) valid |=> !valid)
    else $error("result held");
  a_busy_valid: assert property (@(posedge clk) disable iff (rst)
    $rose(valid) |-> $past(state) == S_DONE) else $error("stray result");
  a_count: assert property (@(posedge clk) disable iff (rst)
    knot_count <= CntW'(MaxKnots)) else $error("knot count overflow");

endmodule
